FILE: hdl/gdsc_pkg.sv
// Shared types, constants and month table for the Gregorian date / serial converter.
// Used by gdsc_ctrl, gdsc_datapath and the top level; depends on nothing.
package gdsc_pkg;

  localparam int unsigned SerialW = 22;
  localparam int unsigned YearW   = 14;
  localparam int unsigned DayW    = 5;
  localparam int unsigned MonW    = 4;
  localparam int unsigned WdW     = 3;
  localparam int unsigned DbW     = 23;  // days before a year, up to year 16383
  localparam int unsigned DoyW    = 9;
  localparam int unsigned Q7W     = 20;
  localparam int unsigned QzW     = 8;

  localparam logic [YearW-1:0] BaseYear   = 14'd1601;
  localparam logic [YearW-1:0] BaseYearM1 = 14'd1600;
  // 1600/4 - 1600/100 + 1600/400, removed when day counts are taken from year-1
  localparam logic [DbW-1:0]   DbBias     = 23'd388;
  localparam logic [DbW-1:0]   SerialMax  = 23'h3F_FFFF;

  // reciprocal multipliers, exact over the operand ranges used here
  localparam int unsigned         Div100Shift = 20;
  localparam logic [YearW-1:0]    Div100Mul   = 14'((2**20 + 99) / 100);
  localparam int unsigned         Div7Shift   = 25;
  localparam logic [22:0]         Div7Mul     = 23'((2**25 + 6) / 7);
  // ceil(2^32 / 365.2425); estimate of the year offset is exact or one high
  localparam int unsigned         YearShift   = 32;
  localparam longint unsigned     YearMulFull =
      ((64'd1 << 32) * 64'd400 + 64'd146096) / 64'd146097;
  localparam logic [23:0]         YearMul     = 24'(YearMulFull);

  localparam logic CmdToSerial = 1'b0;
  localparam logic CmdToDate   = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EST,
    OP_YMUL,
    OP_YSUM,
    OP_CHK,
    OP_DATE,
    OP_WDMUL,
    OP_MON
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   load_out;
  } dp_ctrl_t;

  typedef struct packed {
    logic cmd;
    logic ok;
    logic db_gt;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EST,
    ST_YMUL,
    ST_YSUM,
    ST_CHK,
    ST_DATE,
    ST_WDMUL,
    ST_MON,
    ST_DONE
  } state_e;

  // days before the first of month m in a common year (m = 13 gives the year length)
  function automatic logic [DoyW-1:0] month_start(input logic [MonW-1:0] m);
    logic [DoyW-1:0] v;
    unique case (m)
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      4'd13:   v = 9'd365;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [DoyW-1:0] month_offset(input logic [MonW-1:0] m,
                                                   input logic leap);
    logic [DoyW-1:0] v;
    v = month_start(m);
    if (leap && m > 4'd2) begin
      v = v + 9'd1;
    end
    return v;
  endfunction

endpackage

FILE: hdl/gdsc_ctrl.sv
// Sequencer for the date / serial converter: steps the datapath through one
// conversion and owns the input ready and the output valid. Uses gdsc_pkg.
module gdsc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                command_i,
  input  logic                out_ready_i,
  input  gdsc_pkg::dp_stat_t  stat_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output gdsc_pkg::dp_ctrl_t  ctrl_o
);

  gdsc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gdsc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    ctrl_o.op       = gdsc_pkg::OP_NONE;
    ctrl_o.load_out = 1'b0;
    unique case (state_q)
      gdsc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.op = gdsc_pkg::OP_LOAD;
          state_d   = (command_i == gdsc_pkg::CmdToDate) ? gdsc_pkg::ST_EST
                                                         : gdsc_pkg::ST_YMUL;
        end
      end
      gdsc_pkg::ST_EST: begin
        ctrl_o.op = gdsc_pkg::OP_EST;
        state_d   = stat_i.ok ? gdsc_pkg::ST_YMUL : gdsc_pkg::ST_DONE;
      end
      gdsc_pkg::ST_YMUL: begin
        ctrl_o.op = gdsc_pkg::OP_YMUL;
        state_d   = gdsc_pkg::ST_YSUM;
      end
      gdsc_pkg::ST_YSUM: begin
        ctrl_o.op = gdsc_pkg::OP_YSUM;
        state_d   = (stat_i.cmd == gdsc_pkg::CmdToDate) ? gdsc_pkg::ST_CHK
                                                        : gdsc_pkg::ST_DATE;
      end
      gdsc_pkg::ST_CHK: begin
        // year estimate one high: step back and redo the day count once
        ctrl_o.op = gdsc_pkg::OP_CHK;
        state_d   = stat_i.db_gt ? gdsc_pkg::ST_YMUL : gdsc_pkg::ST_MON;
      end
      gdsc_pkg::ST_DATE: begin
        ctrl_o.op = gdsc_pkg::OP_DATE;
        state_d   = gdsc_pkg::ST_WDMUL;
      end
      gdsc_pkg::ST_WDMUL: begin
        ctrl_o.op = gdsc_pkg::OP_WDMUL;
        state_d   = gdsc_pkg::ST_DONE;
      end
      gdsc_pkg::ST_MON: begin
        ctrl_o.op = gdsc_pkg::OP_MON;
        state_d   = gdsc_pkg::ST_DONE;
      end
      gdsc_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.load_out = 1'b1;
          state_d         = gdsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gdsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctrl_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/gdsc_datapath.sv
// Datapath of the date / serial converter: input and work registers, the
// reciprocal multipliers, day counting, month search and the result register.
// Uses gdsc_pkg; driven by gdsc_ctrl.
module gdsc_datapath #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                                  clk_i,
  input  gdsc_pkg::dp_ctrl_t                    ctrl_i,
  output gdsc_pkg::dp_stat_t                    stat_o,
  input  logic                                  command_i,
  input  logic [gdsc_pkg::DayW-1:0]             day_in_i,
  input  logic [gdsc_pkg::MonW-1:0]             month_in_i,
  input  logic [gdsc_pkg::YearW-1:0]            year_in_i,
  input  logic [gdsc_pkg::SerialW-1:0]          serial_in_i,
  output logic [gdsc_pkg::SerialW-1:0]          serial_out_o,
  output logic [gdsc_pkg::DayW-1:0]             day_out_o,
  output logic [gdsc_pkg::MonW-1:0]             month_out_o,
  output logic [gdsc_pkg::YearW-1:0]            year_out_o,
  output logic [gdsc_pkg::WdW-1:0]              weekday_o,
  output logic                                  valid_res_o
);

  localparam int unsigned NumYears  = MAX_YEAR - 1600;
  localparam int unsigned MaxSerial = NumYears * 365 + NumYears / 4 - NumYears / 100
                                      + NumYears / 400;
  localparam logic [gdsc_pkg::YearW-1:0] YearMax = gdsc_pkg::YearW'(MAX_YEAR);

  // input and work registers
  logic                              cmd_q;
  logic [gdsc_pkg::DayW-1:0]         day_q;
  logic [gdsc_pkg::MonW-1:0]         mon_q;
  logic [gdsc_pkg::YearW-1:0]        year_q;
  logic [gdsc_pkg::SerialW-1:0]      ser_q;
  logic [gdsc_pkg::SerialW-1:0]      t_q;     // zero-based day count
  logic                              ok_q;
  logic [gdsc_pkg::YearW-1:0]        z_q;     // year minus one
  logic [gdsc_pkg::QzW-1:0]          qz_q;    // z / 100
  logic [gdsc_pkg::DbW-1:0]          n365_q;
  logic [gdsc_pkg::DbW-1:0]          db_q;    // days before 1 January of year z+1
  logic                              leap_q;
  logic [gdsc_pkg::Q7W-1:0]          q7_q;    // t / 7
  logic [gdsc_pkg::DoyW-1:0]         doy_q;
  logic [gdsc_pkg::MonW-1:0]         mres_q;
  logic [gdsc_pkg::DayW-1:0]         dres_q;

  // result register
  logic [gdsc_pkg::SerialW-1:0]      serial_out_q;
  logic [gdsc_pkg::DayW-1:0]         day_out_q;
  logic [gdsc_pkg::MonW-1:0]         month_out_q;
  logic [gdsc_pkg::YearW-1:0]        year_out_q;
  logic [gdsc_pkg::WdW-1:0]          weekday_q;
  logic                              valid_res_q;

  // combinational terms
  logic                              in_ok;
  logic [22:0]                       ser_p1;
  logic [46:0]                       est_prod;
  logic [44:0]                       q7_prod;
  logic [27:0]                       qz_prod;
  logic [gdsc_pkg::YearW-1:0]        n_yr;
  logic [gdsc_pkg::DbW-1:0]          n365;
  logic [gdsc_pkg::DbW-1:0]          db_sum;
  logic [gdsc_pkg::YearW-1:0]        hund;
  logic [gdsc_pkg::YearW-1:0]        rz;
  logic                              leap_d;
  logic                              db_gt;
  logic [gdsc_pkg::DbW-1:0]          doy_full;
  logic [gdsc_pkg::DoyW-1:0]         off_m;
  logic [gdsc_pkg::DoyW-1:0]         off_n;
  logic [gdsc_pkg::DoyW-1:0]         mlen;
  logic [gdsc_pkg::DbW-1:0]          v_sum;
  logic                              date_ok;
  logic [gdsc_pkg::MonW-1:0]         mcnt;
  logic [gdsc_pkg::MonW-1:0]         mk;
  logic [gdsc_pkg::DoyW-1:0]         dres_full;

  always_comb begin
    if (command_i == gdsc_pkg::CmdToDate) begin
      in_ok = (serial_in_i != '0) && (32'(serial_in_i) <= 32'(MaxSerial));
    end else begin
      in_ok = (year_in_i >= gdsc_pkg::BaseYear) && (year_in_i <= YearMax)
              && (month_in_i >= 4'd1) && (month_in_i <= 4'd12) && (day_in_i != '0);
    end
  end

  assign ser_p1   = {1'b0, ser_q} + 23'd1;
  assign est_prod = {24'd0, ser_p1} * {23'd0, gdsc_pkg::YearMul};
  assign q7_prod  = {23'd0, t_q} * {22'd0, gdsc_pkg::Div7Mul};
  assign qz_prod  = {14'd0, z_q} * {14'd0, gdsc_pkg::Div100Mul};

  assign n_yr = z_q - gdsc_pkg::BaseYearM1;
  assign n365 = {9'd0, n_yr} * 23'd365;

  // days_before(n) = 365n + z/4 - z/100 + z/400 - 388, with z = 1600 + n
  assign db_sum = n365_q + {11'd0, z_q[gdsc_pkg::YearW-1:2]} - {15'd0, qz_q}
                  + {17'd0, qz_q[gdsc_pkg::QzW-1:2]} - gdsc_pkg::DbBias;

  // leap test on year z+1 from z mod 100 and z / 100
  assign hund   = {6'd0, qz_q} * 14'd100;
  assign rz     = z_q - hund;
  assign leap_d = (z_q[1:0] == 2'b11) && ((rz != 14'd99) || (qz_q[1:0] == 2'b11));

  assign db_gt    = db_q > {1'b0, t_q};
  assign doy_full = {1'b0, t_q} + 23'd1 - db_q;

  assign off_m   = gdsc_pkg::month_offset(mon_q, leap_q);
  assign off_n   = gdsc_pkg::month_offset(mon_q + 4'd1, leap_q);
  assign mlen    = off_n - off_m;
  assign v_sum   = db_q + {14'd0, off_m} + {18'd0, day_q};
  assign date_ok = ok_q && ({4'd0, day_q} <= mlen) && (v_sum <= gdsc_pkg::SerialMax);

  // month: one plus the number of month starts that lie before the day of year
  always_comb begin
    mcnt = '0;
    for (int j = 2; j <= 12; j++) begin
      if (doy_q > gdsc_pkg::month_offset(gdsc_pkg::MonW'(j), leap_q)) begin
        mcnt = mcnt + 4'd1;
      end
    end
    mk        = mcnt + 4'd1;
    dres_full = doy_q - gdsc_pkg::month_offset(mk, leap_q);
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      gdsc_pkg::OP_LOAD: begin
        cmd_q  <= command_i;
        day_q  <= day_in_i;
        mon_q  <= month_in_i;
        year_q <= year_in_i;
        ser_q  <= serial_in_i;
        t_q    <= serial_in_i - 22'd1;
        z_q    <= year_in_i - 14'd1;
        ok_q   <= in_ok;
      end
      gdsc_pkg::OP_EST: begin
        z_q  <= gdsc_pkg::BaseYearM1 + est_prod[gdsc_pkg::YearShift +: gdsc_pkg::YearW];
        q7_q <= q7_prod[gdsc_pkg::Div7Shift +: gdsc_pkg::Q7W];
      end
      gdsc_pkg::OP_YMUL: begin
        qz_q   <= qz_prod[gdsc_pkg::Div100Shift +: gdsc_pkg::QzW];
        n365_q <= n365;
      end
      gdsc_pkg::OP_YSUM: begin
        db_q   <= db_sum;
        leap_q <= leap_d;
      end
      gdsc_pkg::OP_CHK: begin
        if (db_gt) begin
          z_q <= z_q - 14'd1;
        end else begin
          doy_q <= doy_full[gdsc_pkg::DoyW-1:0];
        end
      end
      gdsc_pkg::OP_DATE: begin
        ok_q <= date_ok;
        t_q  <= gdsc_pkg::SerialW'(v_sum - 23'd1);
      end
      gdsc_pkg::OP_WDMUL: begin
        q7_q <= q7_prod[gdsc_pkg::Div7Shift +: gdsc_pkg::Q7W];
      end
      gdsc_pkg::OP_MON: begin
        mres_q <= mk;
        dres_q <= dres_full[gdsc_pkg::DayW-1:0];
      end
      default: begin
      end
    endcase
  end

  // weekday = t - 7q; mod 8 that is t + q, and the true value is below 7
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      valid_res_q <= ok_q;
      weekday_q   <= ok_q ? (t_q[2:0] + q7_q[2:0]) : '0;
      if (cmd_q == gdsc_pkg::CmdToDate) begin
        serial_out_q <= ser_q;
        day_out_q    <= ok_q ? dres_q : '0;
        month_out_q  <= ok_q ? mres_q : '0;
        year_out_q   <= ok_q ? (z_q + 14'd1) : '0;
      end else begin
        serial_out_q <= ok_q ? (t_q + 22'd1) : '0;
        day_out_q    <= day_q;
        month_out_q  <= mon_q;
        year_out_q   <= year_q;
      end
    end
  end

  assign stat_o.cmd   = cmd_q;
  assign stat_o.ok    = ok_q;
  assign stat_o.db_gt = db_gt;

  assign serial_out_o = serial_out_q;
  assign day_out_o    = day_out_q;
  assign month_out_o  = month_out_q;
  assign year_out_o   = year_out_q;
  assign weekday_o    = weekday_q;
  assign valid_res_o  = valid_res_q;

endmodule

FILE: hdl/gregorian_date_serial_converter_top.sv
// Gregorian date <-> serial day number converter (day 1 = Monday 1601-01-01). Command 0
// turns a date into its serial and weekday, command 1 turns a serial into a date and
// weekday; each transfer in gives one transfer out, and a result waiting in the output
// register does not block the next input. One conversion is in flight at a time, run
// by a small sequencer over a shared set of reciprocal multipliers. Command 1 runs the
// year estimate through a single correction pass when it is one high, and an
// out-of-range serial goes straight from the estimate step to the output.
// A finished conversion waits in its last state while the previous result still waits
// for out_ready_i.
// Depends on gdsc_pkg, gdsc_ctrl and gdsc_datapath.
module gregorian_date_serial_converter_top #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [gdsc_pkg::DayW-1:0]     day_in_i,
  input  logic [gdsc_pkg::MonW-1:0]     month_in_i,
  input  logic [gdsc_pkg::YearW-1:0]    year_in_i,
  input  logic [gdsc_pkg::SerialW-1:0]  serial_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gdsc_pkg::SerialW-1:0]  serial_out_o,
  output logic [gdsc_pkg::DayW-1:0]     day_out_o,
  output logic [gdsc_pkg::MonW-1:0]     month_out_o,
  output logic [gdsc_pkg::YearW-1:0]    year_out_o,
  output logic [gdsc_pkg::WdW-1:0]      weekday_o,
  output logic                          valid_res_o
);

  gdsc_pkg::dp_ctrl_t dp_ctrl;
  gdsc_pkg::dp_stat_t dp_stat;

  gdsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .ctrl_o      (dp_ctrl)
  );

  gdsc_datapath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_datapath (
    .clk_i        (clk_i),
    .ctrl_i       (dp_ctrl),
    .stat_o       (dp_stat),
    .command_i    (command_i),
    .day_in_i     (day_in_i),
    .month_in_i   (month_in_i),
    .year_in_i    (year_in_i),
    .serial_in_i  (serial_in_i),
    .serial_out_o (serial_out_o),
    .day_out_o    (day_out_o),
    .month_out_o  (month_out_o),
    .year_out_o   (year_out_o),
    .weekday_o    (weekday_o),
    .valid_res_o  (valid_res_o)
  );

`ifndef SYNTHESIS
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready stayed high after a transfer");

  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |-> weekday_o <= 3'd6)
    else $error("weekday out of range");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |-> month_out_o >= 4'd1 && month_out_o <= 4'd12)
    else $error("month out of range on a valid result");

  a_invalid_weekday: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> weekday_o == 3'd0)
    else $error("weekday not cleared on an invalid result");
`endif

endmodule
